// ===== rtl/clnb_pkg.sv =====
// Shared types and constants for the character panel nibble bus controller.
`default_nettype none

package clnb_pkg;

    // Request function codes.
    typedef enum logic [1:0] {
        FUNC_CMD    = 2'd0,
        FUNC_DATA   = 2'd1,
        FUNC_CURSOR = 2'd2,
        FUNC_STATUS = 2'd3
    } func_t;

    // What the front end waits for after a status read was issued.
    typedef enum logic [1:0] {
        PEND_NONE   = 2'd0,
        PEND_CMD    = 2'd1,
        PEND_DATA   = 2'd2,
        PEND_CURSOR = 2'd3
    } pend_t;

    // Configuration register indexes (word address bits).
    localparam logic [1:0] REG_LINE_WIDTH = 2'd0;
    localparam logic [1:0] REG_ROW2_START = 2'd1;
    localparam logic [1:0] REG_STROBE_WAIT = 2'd2;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [5:0]  LINE_WIDTH_RST  = 6'd24;
    localparam logic [6:0]  ROW2_START_RST  = 7'd64;
    localparam logic [15:0] STROBE_WAIT_RST = 16'd1000;

    localparam logic [7:0] SET_ADDR_CMD = 8'h80;

    // Depth of the run queue between front and back.
    localparam int QDEPTH = 2;

    // Phase numbers inside a run: 0..3 write phases, 4..7 status read phases.
    localparam logic [2:0] PH_FIRST_WRITE = 3'd0;
    localparam logic [2:0] PH_FIRST_READ  = 3'd4;
    localparam logic [2:0] PH_LAST        = 3'd7;

    typedef struct packed {
        logic [5:0]  line_width;
        logic [6:0]  second_row_start;
        logic [15:0] strobe_wait;
    } cfg_t;

    // One bus run: optional byte write followed by a status read.
    typedef struct packed {
        logic       has_byte;
        logic       rs;
        logic [7:0] data;
        logic [6:0] cursor;
    } run_t;

endpackage

`default_nettype wire

// ===== rtl/clnb_if.sv =====
// Valid/ready channel interfaces for requests and bus phase words.
`default_nettype none

interface clnb_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface clnb_phase_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic       read_not_write;
    logic       enable_strobe;
    logic [3:0] bus_nibble;
    logic       bus_drive;
    logic       sample_status;
    logic [6:0] cursor;
    logic       last;

    modport source (output valid, output reg_select, output read_not_write,
                    output enable_strobe, output bus_nibble, output bus_drive,
                    output sample_status, output cursor, output last, input ready);
    modport sink   (input valid, input reg_select, input read_not_write,
                    input enable_strobe, input bus_nibble, input bus_drive,
                    input sample_status, input cursor, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/clnb_front.sv =====
// Front end: accepts request words, tracks panel state and queues bus runs.
`default_nettype none

module clnb_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    clnb_req_if.sink           req,
    input  wire clnb_pkg::cfg_t cfg,
    input  wire logic          q_full,
    output logic               q_push,
    output clnb_pkg::run_t     q_data
);
    import clnb_pkg::*;

    logic [6:0] cursor_reg;
    logic [6:0] cursor_next;
    logic [7:0] target_reg;
    logic [7:0] target_next;
    pend_t      pend_reg;
    pend_t      pend_next;

    logic       accept;
    func_t      func;
    logic [6:0] new_cur;
    logic [7:0] row2_end;
    logic       tgt_gap;
    logic       tgt_past;
    logic       cur_gap;
    logic       cur_past;
    logic       push;
    run_t       run;

    assign req.ready = !q_full;
    assign accept    = req.valid && !q_full;
    assign func      = func_t'(req.func);
    assign new_cur   = req.value[6:0];
    assign row2_end  = {1'b0, cfg.second_row_start} + {2'b00, cfg.line_width};

    // Row checks: in the gap after row one, or past the end of row two.
    assign tgt_gap  = (target_reg >= {2'b00, cfg.line_width})
                   && (target_reg < {1'b0, cfg.second_row_start});
    assign tgt_past = target_reg >= row2_end;
    assign cur_gap  = ({1'b0, new_cur} >= {2'b00, cfg.line_width})
                   && (new_cur < cfg.second_row_start);
    assign cur_past = {1'b0, new_cur} >= row2_end;

    always_comb
    begin
        push        = 1'b0;
        run         = '{has_byte: 1'b0, rs: 1'b0, data: 8'h00, cursor: cursor_reg};
        cursor_next = cursor_reg;
        target_next = target_reg;
        pend_next   = pend_reg;
        unique case (func)
            FUNC_CMD:
            begin
                push         = 1'b1;
                run.has_byte = 1'b1;
                run.data     = req.value;
                pend_next    = PEND_CMD;
            end
            FUNC_DATA:
            begin
                push         = 1'b1;
                run.has_byte = 1'b1;
                run.rs       = 1'b1;
                run.data     = req.value;
                pend_next    = PEND_DATA;
            end
            FUNC_CURSOR:
            begin
                push        = 1'b1;
                target_next = req.value;
                pend_next   = PEND_CURSOR;
            end
            FUNC_STATUS:
            begin
                if (pend_reg != PEND_NONE)
                begin
                    cursor_next  = new_cur;
                    run.cursor   = new_cur;
                    run.has_byte = 1'b1;
                    if (pend_reg == PEND_CURSOR)
                    begin
                        pend_next = PEND_NONE;
                        priority if (tgt_gap)
                        begin
                            push      = 1'b1;
                            run.data  = SET_ADDR_CMD | {1'b0, cfg.second_row_start};
                            pend_next = PEND_CMD;
                        end
                        else if (tgt_past)
                        begin
                            push      = 1'b1;
                            run.data  = SET_ADDR_CMD;
                            pend_next = PEND_CMD;
                        end
                        else if ({1'b0, new_cur} != target_reg)
                        begin
                            push      = 1'b1;
                            run.data  = SET_ADDR_CMD | target_reg;
                            pend_next = PEND_CMD;
                        end
                    end
                    else if (req.value[7])
                    begin
                        // Panel still busy: read the status again.
                        push         = 1'b1;
                        run.has_byte = 1'b0;
                    end
                    else
                    begin
                        pend_next = PEND_NONE;
                        if (pend_reg == PEND_DATA)
                        begin
                            priority if (cur_gap)
                            begin
                                push      = 1'b1;
                                run.data  = SET_ADDR_CMD | {1'b0, cfg.second_row_start};
                                pend_next = PEND_CMD;
                            end
                            else if (cur_past)
                            begin
                                push      = 1'b1;
                                run.data  = SET_ADDR_CMD;
                                pend_next = PEND_CMD;
                            end
                        end
                    end
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    assign q_push = accept && push;
    assign q_data = run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            target_reg <= '0;
            pend_reg   <= PEND_NONE;
        end
        else if (accept)
        begin
            cursor_reg <= cursor_next;
            target_reg <= target_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/clnb_queue.sv =====
// Small register queue that holds bus runs between front and back.
`default_nettype none

module clnb_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire clnb_pkg::run_t push_data,
    output logic                full,
    input  wire logic           pop,
    output logic                not_empty,
    output clnb_pkg::run_t      pop_data
);
    import clnb_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    run_t          mem_reg [QDEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == CW'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/clnb_back.sv =====
// Back end: plays each bus run out as timed phase words.
`default_nettype none

module clnb_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire clnb_pkg::cfg_t cfg,
    input  wire logic           q_not_empty,
    input  wire clnb_pkg::run_t q_data,
    output logic                q_pop,
    clnb_phase_if.source        rsp
);
    import clnb_pkg::*;

    logic        busy_reg;
    logic        busy_next;
    run_t        run_reg;
    run_t        run_next;
    logic [2:0]  phase_reg;
    logic [2:0]  phase_next;
    logic [15:0] wait_reg;
    logic [15:0] wait_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        rs_reg, rs_next;
    logic        rnw_reg, rnw_next;
    logic        en_reg, en_next;
    logic [3:0]  nib_reg, nib_next;
    logic        drive_reg, drive_next;
    logic        smp_reg, smp_next;
    logic [6:0]  cur_reg, cur_next;
    logic        last_reg, last_next;

    logic        held;
    logic        emit;
    logic        is_read;

    assign q_pop   = !busy_reg && q_not_empty;
    assign held    = wait_reg >= cfg.strobe_wait;
    assign emit    = busy_reg && held && (!out_valid_reg || rsp.ready);
    assign is_read = phase_reg[2];

    always_comb
    begin
        busy_next      = busy_reg;
        run_next       = run_reg;
        phase_next     = phase_reg;
        wait_next      = wait_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        rs_next        = rs_reg;
        rnw_next       = rnw_reg;
        en_next        = en_reg;
        nib_next       = nib_reg;
        drive_next     = drive_reg;
        smp_next       = smp_reg;
        cur_next       = cur_reg;
        last_next      = last_reg;

        if (q_pop)
        begin
            busy_next  = 1'b1;
            run_next   = q_data;
            phase_next = q_data.has_byte ? PH_FIRST_WRITE : PH_FIRST_READ;
            wait_next  = '0;
        end
        else if (emit)
        begin
            out_valid_next = 1'b1;
            rs_next        = is_read ? 1'b0 : run_reg.rs;
            rnw_next       = is_read;
            en_next        = !phase_reg[0];
            nib_next       = is_read ? 4'h0
                           : (phase_reg[1] ? run_reg.data[3:0] : run_reg.data[7:4]);
            drive_next     = !is_read;
            smp_next       = (phase_reg == PH_LAST);
            cur_next       = run_reg.cursor;
            last_next      = (phase_reg == PH_LAST);
            wait_next      = '0;
            if (phase_reg == PH_LAST)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                phase_next = phase_reg + 1'b1;
            end
        end
        else if (busy_reg && !held)
        begin
            wait_next = wait_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= PH_FIRST_WRITE;
            wait_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg   <= run_next;
        rs_reg    <= rs_next;
        rnw_reg   <= rnw_next;
        en_reg    <= en_next;
        nib_reg   <= nib_next;
        drive_reg <= drive_next;
        smp_reg   <= smp_next;
        cur_reg   <= cur_next;
        last_reg  <= last_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.reg_select     = rs_reg;
    assign rsp.read_not_write = rnw_reg;
    assign rsp.enable_strobe  = en_reg;
    assign rsp.bus_nibble     = nib_reg;
    assign rsp.bus_drive      = drive_reg;
    assign rsp.sample_status  = smp_reg;
    assign rsp.cursor         = cur_reg;
    assign rsp.last           = last_reg;

endmodule

`default_nettype wire

// ===== rtl/char_lcd_nibble_bus_controller_top.sv =====
// Top level of the character panel nibble bus controller.
//
//  Channel  Direction  Carries
//  -------  ---------  ------------------------------------------------------
//  req      in         one request word: func and value (command, data byte,
//                      cursor target, or the panel status byte read back)
//  rsp      out        one bus phase word: control lines, nibble, drive,
//                      status sample flag, cursor and end-of-run mark
//  APB      in/out     line_width, second_row_start, strobe_wait registers
//
// Each bus phase is held by the phase timer in the back end until it has counted
// up to strobe_wait, so a run of 8 phases (byte plus status read) is played out
// phase by phase, and a status-only run plays only its status read phases.
// The front end accepts a request word every cycle while the run queue has room.
// Reset is asynchronous and active low; it clears the panel tracking state,
// the queue and the phase sequencer and loads the register defaults.
// A stalled rsp channel holds the current phase word and stops the sequencer;
// the front keeps accepting words until the queue fills.
`default_nettype none

module char_lcd_nibble_bus_controller_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    clnb_req_if.sink                           req,
    clnb_phase_if.source                       rsp,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [clnb_pkg::APB_AW-1:0]   paddr,
    input  wire logic [clnb_pkg::APB_DW-1:0]   pwdata,
    output logic      [clnb_pkg::APB_DW-1:0]   prdata,
    output logic                               pready
);
    import clnb_pkg::*;

    // Configuration registers.
    logic [5:0]  line_width_reg;
    logic [6:0]  row2_start_reg;
    logic [15:0] strobe_wait_reg;
    logic        cfg_write;
    logic [1:0]  reg_index;
    cfg_t        cfg;

    // Queue between front and back.
    logic        q_push;
    run_t        q_push_data;
    logic        q_full;
    logic        q_pop;
    logic        q_not_empty;
    run_t        q_pop_data;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg  <= LINE_WIDTH_RST;
            row2_start_reg  <= ROW2_START_RST;
            strobe_wait_reg <= STROBE_WAIT_RST;
        end
        else if (cfg_write)
        begin
            // Writes to an address beyond the register list are dropped.
            unique case (reg_index)
                REG_LINE_WIDTH:  line_width_reg  <= pwdata[5:0];
                REG_ROW2_START:  row2_start_reg  <= pwdata[6:0];
                REG_STROBE_WAIT: strobe_wait_reg <= pwdata[15:0];
                default:         line_width_reg  <= line_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_LINE_WIDTH:  prdata = {{(APB_DW - 6){1'b0}}, line_width_reg};
            REG_ROW2_START:  prdata = {{(APB_DW - 7){1'b0}}, row2_start_reg};
            REG_STROBE_WAIT: prdata = {{(APB_DW - 16){1'b0}}, strobe_wait_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg = '{line_width: line_width_reg,
                   second_row_start: row2_start_reg,
                   strobe_wait: strobe_wait_reg};

    // The front end classifies each request against the tracked cursor and
    // pending status, and queues at most one bus run per request.
    clnb_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cfg    (cfg),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_push_data)
    );

    clnb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_pop_data)
    );

    // The back end turns each run into enable-high/enable-low phase pairs, with the
    // data nibble set in the same phase word that raises enable, then the status read.
    clnb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_not_empty (q_not_empty),
        .q_data      (q_pop_data),
        .q_pop       (q_pop),
        .rsp         (rsp)
    );

endmodule

`default_nettype wire
